// ===== rtl/mmce_pkg.sv =====
// Types, codes, CRC helpers and the modulo-255 adder shared by the multi-mode checksum engine.
package mmce_pkg;

    localparam logic [7:0]  CRC8_POLY   = 8'h07;
    localparam logic [15:0] CRC16_POLY  = 16'h1021;
    localparam logic [7:0]  FLETCHER_MOD = 8'd255;
    localparam logic [8:0]  XOR_LIMIT   = 9'd16;
    localparam logic [8:0]  COUNT_MAX   = 9'd256;

    localparam logic [2:0]  MODE_RESET       = 3'd4;
    localparam logic [7:0]  CRC8_INIT_RESET  = 8'h00;
    localparam logic [15:0] CRC16_INIT_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_MODE       = 2'd0,
        CFG_CRC8_INIT  = 2'd1,
        CFG_CRC16_INIT = 2'd2,
        CFG_NONE       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_CRC8     = 3'd0,
        MODE_CRC16    = 3'd1,
        MODE_XOR      = 3'd2,
        MODE_FLETCHER = 3'd3,
        MODE_AUTO     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ALG_CRC8     = 2'd0,
        ALG_CRC16    = 2'd1,
        ALG_XOR      = 2'd2,
        ALG_FLETCHER = 2'd3
    } alg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] expected_checksum;
    } in_item_t;

    typedef struct packed {
        logic [15:0] checksum_value;
        logic [1:0]  checksum_bytes;
        logic [1:0]  algorithm_used;
        logic        checksum_match;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  crc8_init;
        logic [15:0] crc16_init;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  crc8;
        logic [15:0] crc16;
        logic [7:0]  xor_sum;
        logic [7:0]  fl_low;
        logic [7:0]  fl_high;
        logic [8:0]  count;
    } run_state_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Sum of two byte values reduced modulo 255 by one conditional subtraction; exact if one is below 255.
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, FLETCHER_MOD}) begin
            s = s - {1'b0, FLETCHER_MOD};
        end
        return s[7:0];
    endfunction

endpackage

// ===== rtl/mmce_datapath.sv =====
// Per-byte update of the running checksums and result selection.
module mmce_datapath (
    input  mmce_pkg::cfg_t       cfg,
    input  mmce_pkg::run_state_t state,
    input  mmce_pkg::in_item_t   item,
    output mmce_pkg::run_state_t state_next,
    output mmce_pkg::out_item_t  result
);
    import mmce_pkg::*;

    logic [7:0]  crc8_start;
    logic [15:0] crc16_start;
    alg_t        alg;
    logic [15:0] value;

    always_comb
    begin
        crc8_start  = (state.count == 9'd0) ? cfg.crc8_init  : state.crc8;
        crc16_start = (state.count == 9'd0) ? cfg.crc16_init : state.crc16;

        state_next.crc8    = crc8_byte(crc8_start, item.data_byte);
        state_next.crc16   = crc16_byte(crc16_start, item.data_byte);
        state_next.xor_sum = state.xor_sum ^ item.data_byte;
        state_next.fl_low  = add_mod255(state.fl_low, item.data_byte);
        state_next.fl_high = add_mod255(state.fl_high, state_next.fl_low);
        state_next.count   = (state.count == COUNT_MAX) ? state.count : state.count + 9'd1;

        unique case (cfg.mode)
            MODE_CRC8:     alg = ALG_CRC8;
            MODE_CRC16:    alg = ALG_CRC16;
            MODE_XOR:      alg = ALG_XOR;
            MODE_FLETCHER: alg = ALG_FLETCHER;
            default:
            begin
                if (state_next.count < XOR_LIMIT) begin
                    alg = ALG_XOR;
                end else if (state_next.count < COUNT_MAX) begin
                    alg = ALG_CRC8;
                end else begin
                    alg = ALG_CRC16;
                end
            end
        endcase

        unique case (alg)
            ALG_CRC8:
            begin
                value                 = {8'h00, state_next.crc8};
                result.checksum_bytes = 2'd1;
            end
            ALG_CRC16:
            begin
                value                 = state_next.crc16;
                result.checksum_bytes = 2'd2;
            end
            ALG_XOR:
            begin
                value                 = {8'h00, state_next.xor_sum};
                result.checksum_bytes = 2'd1;
            end
            default:
            begin
                value                 = {state_next.fl_high, state_next.fl_low};
                result.checksum_bytes = 2'd2;
            end
        endcase

        result.checksum_value = value;
        result.algorithm_used = alg;
        result.checksum_match = (value == item.expected_checksum);
    end

endmodule

// ===== rtl/multi_mode_checksum_engine.sv =====
// Top level of the multi-mode checksum engine: config registers, running state, output skid.
// A last-byte result is registered into the output register, or the skid while it stalls.
// Throughput: one byte per cycle; input stalls only while a result waits in the skid register.
// The running-state update for a byte is one combinational pass between registers.
// Reset: mode auto, CRC-8 start 0x00, CRC-16 start 0xFFFF, running values and count cleared,
// output and skid registers empty.
module multi_mode_checksum_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mmce_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output mmce_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import mmce_pkg::*;

    cfg_t       cfg_reg;
    run_state_t state_reg;
    run_state_t state_next;
    out_item_t  result;
    out_item_t  out_reg;
    out_item_t  skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       in_fire;
    logic       res_valid;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign res_valid = in_fire && in_item.last_byte;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    mmce_datapath u_datapath (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_item),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_RESET;
            cfg_reg.crc8_init  <= CRC8_INIT_RESET;
            cfg_reg.crc16_init <= CRC16_INIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:       cfg_reg.mode       <= cfg_data[2:0];
                CFG_CRC8_INIT:  cfg_reg.crc8_init  <= cfg_data[7:0];
                CFG_CRC16_INIT: cfg_reg.crc16_init <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Clear running values after the last byte of a message.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_fire)
        begin
            if (in_item.last_byte)
            begin
                state_reg <= '0;
            end
            else
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (res_valid)
        begin
            skid_reg <= result;
        end
    end

endmodule
